// File: design/bra_pkg.sv
// Shared types and constants of the bitmap region allocator.
`default_nettype none
package bra_pkg;

  localparam int unsigned UNIT_BYTES_DEF  = 4096;
  localparam int unsigned TOTAL_UNITS_DEF = 1024;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned BYTES_W    = 23;
  localparam int unsigned RAND_W     = 31;
  localparam int unsigned UNIT_OUT_W = 10;
  // widest unit index (TOTAL_UNITS up to 65536)
  localparam int unsigned IDX_MAX_W  = 16;
  // page count and factor never exceed 2^22 for a unit of two bytes or more
  localparam int unsigned PG_W       = 23;
  localparam int unsigned FAC_W      = 23;
  localparam int unsigned END_W      = PG_W + 1;
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned WORD_W     = 32;

  typedef struct packed {
    logic               random_mode;
    logic [BYTES_W-1:0] request_bytes;
    logic [BYTES_W-1:0] align_bytes;
    logic [RAND_W-1:0]  random_value;
  } req_t;

  typedef struct packed {
    logic                  status;
    logic [UNIT_OUT_W-1:0] start_unit;
    logic [ADDR_W-1:0]     start_address;
  } rsp_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic                 go;
    logic [IDX_MAX_W-1:0] first;
    logic [IDX_MAX_W-1:0] last;
  } map_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } map_sts_t;

endpackage
`default_nettype wire

// File: design/bra_stream_if.sv
// Valid/ready stream channel carrying one word of payload.
`default_nettype none
interface bra_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/bra_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bra_div
  import bra_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.go) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DIV_W]) begin
        rem_d = diff[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// File: design/bra_map.sv
// Page-used bitmap in a word-wide memory with check and set sequencing.
`default_nettype none
module bra_map
  import bra_pkg::*;
#(
  parameter int unsigned TOTAL_UNITS = TOTAL_UNITS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  map_cmd_t cmd_i,
  output map_sts_t sts_o
);

  localparam int unsigned DEPTH = (TOTAL_UNITS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFF_W = $clog2(WORD_W);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CRD  = 3'd2;
  localparam logic [2:0] ST_CCK  = 3'd3;
  localparam logic [2:0] ST_SRD  = 3'd4;
  localparam logic [2:0] ST_SWR  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  logic [2:0]       st_q, st_d;
  logic [WA_W-1:0]  w_q, w_d;
  logic [WA_W-1:0]  fw_q, fw_d;
  logic [WA_W-1:0]  lw_q, lw_d;
  logic [OFF_W-1:0] flo_q, flo_d;
  logic [OFF_W-1:0] lhi_q, lhi_d;
  logic             hit_q, hit_d;

  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [OFF_W-1:0]  lo;
  logic [OFF_W-1:0]  hi;
  logic [WORD_W-1:0] mask;

  // bits of the current word that lie inside [first, last]
  assign lo   = (w_q == fw_q) ? flo_q : '0;
  assign hi   = (w_q == lw_q) ? lhi_q : OFF_W'(WORD_W - 1);
  assign mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi));

  always_comb begin
    st_d    = st_q;
    w_d     = w_q;
    fw_d    = fw_q;
    lw_d    = lw_q;
    flo_d   = flo_q;
    lhi_d   = lhi_q;
    hit_d   = hit_q;
    wr_en   = 1'b0;
    wr_data = '0;
    case (st_q)
      ST_CLR: begin
        wr_en = 1'b1;
        w_d   = w_q + 1'b1;
        if (w_q == WA_W'(DEPTH - 1)) begin
          w_d  = '0;
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_i.go) begin
          fw_d  = WA_W'(cmd_i.first >> OFF_W);
          lw_d  = WA_W'(cmd_i.last >> OFF_W);
          flo_d = cmd_i.first[OFF_W-1:0];
          lhi_d = cmd_i.last[OFF_W-1:0];
          w_d   = WA_W'(cmd_i.first >> OFF_W);
          hit_d = 1'b0;
          st_d  = ST_CRD;
        end
      end
      ST_CRD: st_d = ST_CCK;
      ST_CCK: begin
        if ((rd_data_q & mask) != '0) begin
          hit_d = 1'b1;
          st_d  = ST_FIN;
        end else if (w_q == lw_q) begin
          w_d  = fw_q;
          st_d = ST_SRD;
        end else begin
          w_d  = w_q + 1'b1;
          st_d = ST_CRD;
        end
      end
      ST_SRD: st_d = ST_SWR;
      ST_SWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_q | mask;
        if (w_q == lw_q) begin
          st_d = ST_FIN;
        end else begin
          w_d  = w_q + 1'b1;
          st_d = ST_SRD;
        end
      end
      ST_FIN: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLR;
      w_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      w_q   <= w_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_q  <= fw_d;
    lw_q  <= lw_d;
    flo_q <= flo_d;
    lhi_q <= lhi_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[w_q] <= wr_data;
    end
    rd_data_q <= mem_q[w_q];
  end

  assign sts_o.ready = (st_q == ST_IDLE);
  assign sts_o.done  = (st_q == ST_FIN);
  assign sts_o.hit   = hit_q;

endmodule
`default_nettype wire

// File: design/bitmap_region_allocator_top.sv
// Bitmap page allocator: one placement result per request word.
// Sequential mode runs range check, map pass and output; random mode first runs two divisions
//   (bound and modulo); the map pass checks the 32-bit map words spanned, then sets them if none is used.
// The next request is taken in the cycle after the result loads; an out-of-range block skips
//   the map pass. A result waiting in the output register holds the block.
// Reset: map swept clear, one word a cycle, (TOTAL_UNITS+31)/32 cycles, before the first
//   request; bump pointer and base address reset to zero. UNIT_BYTES must be a power of two.
`default_nettype none
module bitmap_region_allocator_top
  import bra_pkg::*;
#(
  parameter int unsigned UNIT_BYTES  = UNIT_BYTES_DEF,
  parameter int unsigned TOTAL_UNITS = TOTAL_UNITS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire [ADDR_W-1:0]  cfg_wdata_i,
  bra_stream_if.sink        req_i,
  bra_stream_if.source      rsp_o
);

  localparam int unsigned IDX_W = $clog2(TOTAL_UNITS);
  localparam int unsigned UB_SH = $clog2(UNIT_BYTES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BND  = 4'd3;
  localparam logic [3:0] ST_MOD  = 4'd4;
  localparam logic [3:0] ST_RNG  = 4'd6;
  localparam logic [3:0] ST_MAP  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]         st_q, st_d;
  logic [ADDR_W-1:0]  base_q;
  logic [IDX_W-1:0]   bump_q, bump_d;
  logic               mode_q, mode_d;
  logic [RAND_W-1:0]  rnd_q, rnd_d;
  logic [FAC_W-1:0]   fac_q, fac_d;
  logic [PG_W-1:0]    pages_q, pages_d;
  logic [IDX_W-1:0]   start_q, start_d;
  logic [END_W-1:0]   end_q, end_d;
  logic [ADDR_W-1:0]  off_q, off_d;
  logic               ok_q, ok_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  map_cmd_t map_cmd;
  map_sts_t map_sts;

  logic               accept;
  logic [BYTES_W-1:0] size_eff;
  logic [BYTES_W-1:0] pg_bytes;
  logic [FAC_W-1:0]   fac_raw;
  logic [FAC_W-1:0]   fac_eff;
  logic [END_W-1:0]   end_sum;
  logic [DIV_W-1:0]   bound;
  logic [IDX_W+FAC_W-1:0] prod;

  assign req_i.ready = (st_q == ST_IDLE) && map_sts.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign size_eff    = (req_i.payload.request_bytes < req_i.payload.align_bytes)
                     ? req_i.payload.align_bytes : req_i.payload.request_bytes;
  // random mode keeps the requested size
  assign pg_bytes    = req_i.payload.random_mode ? req_i.payload.request_bytes : size_eff;
  assign fac_raw     = FAC_W'(req_i.payload.align_bytes >> UB_SH);
  assign fac_eff     = (fac_raw == '0) ? FAC_W'(1) : fac_raw;
  assign end_sum     = END_W'(start_q) + END_W'(pages_q);
  assign bound       = (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
  assign prod        = (IDX_W+FAC_W)'(div_rsp.remainder[IDX_W-1:0]) * (IDX_W+FAC_W)'(fac_q);

  bra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bra_map #(
    .TOTAL_UNITS (TOTAL_UNITS)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (map_cmd),
    .sts_o  (map_sts)
  );

  always_comb begin
    st_d        = st_q;
    bump_d      = bump_q;
    mode_d      = mode_q;
    rnd_d       = rnd_q;
    fac_d       = fac_q;
    pages_d     = pages_q;
    start_d     = start_q;
    end_d       = end_q;
    off_d       = off_q;
    ok_d        = ok_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    div_req     = '0;
    map_cmd     = '0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d  = req_i.payload.random_mode;
          rnd_d   = req_i.payload.random_value;
          fac_d   = fac_eff;
          pages_d = PG_W'(pg_bytes >> UB_SH) + PG_W'(1);
          if (req_i.payload.random_mode) begin
            div_req.go       = 1'b1;
            div_req.dividend = DIV_W'(TOTAL_UNITS);
            div_req.divisor  = DIV_W'(fac_eff);
            st_d             = ST_BND;
          end else begin
            start_d = bump_q;
            st_d    = ST_RNG;
          end
        end
      end
      ST_BND: begin
        if (div_rsp.done) begin
          div_req.go       = 1'b1;
          div_req.dividend = DIV_W'(rnd_q);
          div_req.divisor  = bound;
          st_d             = ST_MOD;
        end
      end
      ST_MOD: begin
        // remainder times factor stays below TOTAL_UNITS
        if (div_rsp.done) begin
          start_d = IDX_W'(prod);
          st_d    = ST_RNG;
        end
      end
      ST_RNG: begin
        end_d = end_sum;
        off_d = ADDR_W'(start_q) << UB_SH;
        if (end_sum >= END_W'(TOTAL_UNITS)) begin
          ok_d = 1'b0;
          st_d = ST_OUT;
        end else begin
          map_cmd.go    = 1'b1;
          map_cmd.first = IDX_MAX_W'(start_q);
          map_cmd.last  = IDX_MAX_W'(end_sum - END_W'(1));
          st_d          = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_sts.done) begin
          ok_d = !map_sts.hit;
          if (!map_sts.hit && !mode_q) begin
            bump_d = IDX_W'(end_q);
          end
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          if (ok_q) begin
            rsp_d.status        = 1'b0;
            rsp_d.start_unit    = UNIT_OUT_W'(DIV_W'(start_q));
            rsp_d.start_address = base_q + off_q;
          end else begin
            rsp_d = '0;
            rsp_d.status = 1'b1;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      bump_q      <= '0;
      base_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      bump_q      <= bump_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    rnd_q   <= rnd_d;
    fac_q   <= fac_d;
    pages_q <= pages_d;
    start_q <= start_d;
    end_q   <= end_d;
    off_q   <= off_d;
    ok_q    <= ok_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule
`default_nettype wire
